// File: rtl/core/mhfp_pkg.sv
// Shared types and codes of the message header field parser.
// Holds the classified character item, the result payload, error and field codes.
// No dependencies; compile this file first.
package mhfp_pkg;

   // Error codes carried in error_code of a result.
   localparam logic [2:0] ERR_NONE         = 3'd0;
   localparam logic [2:0] ERR_FIELD_COUNT  = 3'd1;
   localparam logic [2:0] ERR_CALLSIGN     = 3'd2;
   localparam logic [2:0] ERR_TAIL         = 3'd3;
   localparam logic [2:0] ERR_IDENT        = 3'd4;
   localparam logic [2:0] ERR_TIME         = 3'd5;
   localparam logic [2:0] ERR_NO_SLASH     = 3'd6;
   localparam logic [2:0] ERR_CALLSIGN_LEN = 3'd7;

   // Header field positions; FIELD_EXCESS marks more than four fields.
   localparam logic [2:0] FIELD_CALLSIGN = 3'd0;
   localparam logic [2:0] FIELD_TAIL     = 3'd1;
   localparam logic [2:0] FIELD_IDENT    = 3'd2;
   localparam logic [2:0] FIELD_TIME     = 3'd3;
   localparam logic [2:0] FIELD_EXCESS   = 3'd4;

   // Queue between the classifier and the parser.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // One character after classification.
   typedef struct packed {
      logic [7:0] code;
      logic       last;
      logic       is_slash;
      logic       is_comma;
      logic       is_alnum;
      logic       is_digit;
      logic       is_hex;
      logic       is_dot;
      logic       is_tail;
      logic [3:0] nibble;
   } char_item_type;

   // One parsed header result.
   typedef struct packed {
      logic        ok;
      logic [2:0]  error_code;
      logic [63:0] callsign;
      logic [3:0]  callsign_len;
      logic [55:0] tail;
      logic [2:0]  tail_len;
      logic        has_ident;
      logic [23:0] ident_value;
      logic        has_time;
      logic [4:0]  hours;
      logic [5:0]  minutes;
      logic [5:0]  seconds;
   } rsp_payload_type;

endpackage

// File: rtl/core/mhfp_if.sv
// Valid/ready channel interfaces of the message header field parser.
// mhfp_req_if carries message characters, mhfp_rsp_if carries header results.
// No dependencies.
interface mhfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink (input valid, input char_code, input last, output ready);
endinterface

interface mhfp_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic [2:0]  error_code;
   logic [63:0] callsign;
   logic [3:0]  callsign_len;
   logic [55:0] tail;
   logic [2:0]  tail_len;
   logic        has_ident;
   logic [23:0] ident_value;
   logic        has_time;
   logic [4:0]  hours;
   logic [5:0]  minutes;
   logic [5:0]  seconds;

   modport source (output valid, output ok, output error_code, output callsign,
                   output callsign_len, output tail, output tail_len, output has_ident,
                   output ident_value, output has_time, output hours, output minutes,
                   output seconds, input ready);
   modport sink (input valid, input ok, input error_code, input callsign,
                 input callsign_len, input tail, input tail_len, input has_ident,
                 input ident_value, input has_time, input hours, input minutes,
                 input seconds, output ready);
endinterface

// File: rtl/core/mhfp_front.sv
// Front stage: accepts message characters and registers their character classes.
// Depends on mhfp_pkg.
module mhfp_front
   import mhfp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [7:0]    char_code,
   input  logic          last,
   output logic          out_valid,
   input  logic          out_ready,
   output char_item_type out_item
);

   logic          valid_ff;
   logic          valid_in;
   char_item_type item_ff;
   char_item_type item_in;
   char_item_type classified;
   logic          is_upper;
   logic          is_af;

   always_comb begin
      is_upper            = (char_code >= 8'h41) && (char_code <= 8'h5A);
      is_af               = (char_code >= 8'h41) && (char_code <= 8'h46);
      classified.code     = char_code;
      classified.last     = last;
      classified.is_slash = (char_code == 8'h2F);
      classified.is_comma = (char_code == 8'h2C);
      classified.is_digit = (char_code >= 8'h30) && (char_code <= 8'h39);
      classified.is_alnum = is_upper || classified.is_digit;
      classified.is_hex   = classified.is_digit || is_af;
      classified.is_dot   = (char_code == 8'h2E);
      classified.is_tail  = classified.is_alnum || classified.is_dot || (char_code == 8'h2D);
      // Letters A to F map to 10 to 15 from their low nibble 1 to 6.
      classified.nibble   = classified.is_digit ? char_code[3:0] : (char_code[3:0] + 4'd9);
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
         item_in  = classified;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

// File: rtl/core/mhfp_queue.sv
// Short FIFO of classified characters between the front and back stages.
// Depends on mhfp_pkg.
module mhfp_queue
   import mhfp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  char_item_type in_item,
   output logic          out_valid,
   input  logic          out_ready,
   output char_item_type out_item
);

   char_item_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]     wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]     wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]     rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0]     rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]     count_ff;
   logic [QUEUE_CNT_W-1:0]     count_in;
   logic                       push;
   logic                       pop;

   assign in_ready  = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// File: rtl/core/mhfp_back.sv
// Back stage: runs the header field parser on classified characters and holds
// the result in an output register. Depends on mhfp_pkg.
module mhfp_back
   import mhfp_pkg::*;
#(
   parameter int unsigned MAX_CALLSIGN = 8
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  char_item_type   in_item,
   output logic            out_valid,
   input  logic            out_ready,
   output rsp_payload_type out_payload
);

   logic [2:0]      field_index_ff, field_index_in;
   logic [3:0]      char_in_field_ff, char_in_field_in;
   logic [63:0]     callsign_ff, callsign_in;
   logic [55:0]     tail_ff, tail_in;
   logic [2:0]      tail_count_ff, tail_count_in;
   logic            seen_non_dot_ff, seen_non_dot_in;
   logic [23:0]     ident_ff, ident_in;
   logic [23:0]     time_digits_ff, time_digits_in;
   logic [2:0]      first_error_ff, first_error_in;
   logic            header_done_ff, header_done_in;
   logic [3:0]      cs_len_ff, cs_len_in;
   logic            ident_empty_ff, ident_empty_in;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   logic            take;
   logic            emit;
   rsp_payload_type result;
   logic [3:0]      n;
   logic [7:0]      c;
   logic [3:0]      cs_offset;
   logic [7:0]      hours_full, minutes_full, seconds_full;
   logic            time_bad;
   logic [2:0]      end_code;
   logic [2:0]      first_error_end;
   logic [3:0]      cs_len_end;
   logic            ident_empty_end;
   logic [2:0]      slash_err;
   logic [2:0]      char_code_err;

   function automatic logic [7:0] bcd_pair(input logic [3:0] hi, input logic [3:0] lo);
      return {1'b0, hi, 3'b000} + {3'b000, hi, 1'b0} + {4'b0000, lo};
   endfunction

   function automatic logic [7:0] prefix_char(input logic [1:0] idx);
      logic [7:0] ch;
      unique case (idx)
         2'd0:    ch = 8'h46;   // F
         2'd1:    ch = 8'h4D;   // M
         2'd2:    ch = 8'h48;   // H
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   assign take        = in_valid && in_ready;
   assign in_ready    = !out_valid_ff || out_ready;
   assign out_valid   = out_valid_ff;
   assign out_payload = rsp_ff;
   assign n           = char_in_field_ff;
   assign c           = in_item.code;
   assign cs_offset   = n - 4'd3;

   assign hours_full   = bcd_pair(time_digits_ff[23:20], time_digits_ff[19:16]);
   assign minutes_full = bcd_pair(time_digits_ff[15:12], time_digits_ff[11:8]);
   assign seconds_full = bcd_pair(time_digits_ff[7:4], time_digits_ff[3:0]);
   assign time_bad     = (hours_full > 8'd23) || (minutes_full > 8'd59) ||
                         (seconds_full > 8'd59);

   // Checks that apply when the current field is closed by a comma or slash.
   always_comb begin
      end_code = ERR_NONE;
      case (field_index_ff)
         FIELD_CALLSIGN: begin
            if (n < 4'd4) begin
               end_code = ERR_CALLSIGN;
            end else if ({1'b0, n} > 5'(3 + MAX_CALLSIGN)) begin
               end_code = ERR_CALLSIGN_LEN;
            end
         end
         FIELD_TAIL: begin
            if (n != 4'd7) begin
               end_code = ERR_TAIL;
            end
         end
         FIELD_IDENT: begin
            if ((n != 4'd0) && (n != 4'd6)) begin
               end_code = ERR_IDENT;
            end
         end
         FIELD_TIME: begin
            if ((n != 4'd6) || time_bad) begin
               end_code = ERR_TIME;
            end
         end
         default: end_code = ERR_NONE;
      endcase
      first_error_end = (first_error_ff != ERR_NONE) ? first_error_ff : end_code;
      if (n < 4'd3) begin
         cs_len_end = 4'd0;
      end else if (n > 4'd11) begin
         cs_len_end = 4'd8;
      end else begin
         cs_len_end = cs_offset;
      end
      ident_empty_end = (field_index_ff == FIELD_IDENT) ? (n == 4'd0) : ident_empty_ff;
      if ((field_index_ff == FIELD_CALLSIGN) || (field_index_ff == FIELD_EXCESS)) begin
         slash_err = ERR_FIELD_COUNT;
      end else if ((first_error_end == ERR_NONE) && (field_index_ff == FIELD_IDENT) &&
                   ident_empty_end) begin
         slash_err = ERR_IDENT;
      end else begin
         slash_err = first_error_end;
      end
   end

   always_comb begin
      field_index_in   = field_index_ff;
      char_in_field_in = char_in_field_ff;
      callsign_in      = callsign_ff;
      tail_in          = tail_ff;
      tail_count_in    = tail_count_ff;
      seen_non_dot_in  = seen_non_dot_ff;
      ident_in         = ident_ff;
      time_digits_in   = time_digits_ff;
      first_error_in   = first_error_ff;
      header_done_in   = header_done_ff;
      cs_len_in        = cs_len_ff;
      ident_empty_in   = ident_empty_ff;
      emit             = 1'b0;
      result           = '0;
      char_code_err    = ERR_NONE;

      if (take) begin
         if (!header_done_ff) begin
            if (in_item.is_slash) begin
               emit              = 1'b1;
               header_done_in    = 1'b1;
               result.error_code = slash_err;
               if (slash_err == ERR_NONE) begin
                  result.ok           = 1'b1;
                  result.callsign     = callsign_ff;
                  result.callsign_len = cs_len_ff;
                  result.tail         = tail_ff;
                  result.tail_len     = tail_count_ff;
                  if ((field_index_ff >= FIELD_IDENT) && !ident_empty_end) begin
                     result.has_ident   = 1'b1;
                     result.ident_value = ident_ff;
                  end
                  if (field_index_ff == FIELD_TIME) begin
                     result.has_time = 1'b1;
                     result.hours    = hours_full[4:0];
                     result.minutes  = minutes_full[5:0];
                     result.seconds  = seconds_full[5:0];
                  end
               end
            end else if (in_item.last) begin
               emit              = 1'b1;
               result.error_code = ERR_NO_SLASH;
            end else if (in_item.is_comma) begin
               first_error_in   = first_error_end;
               char_in_field_in = 4'd0;
               if (field_index_ff == FIELD_CALLSIGN) begin
                  cs_len_in = cs_len_end;
               end
               if (field_index_ff == FIELD_IDENT) begin
                  ident_empty_in = (n == 4'd0);
               end
               if (field_index_ff != FIELD_EXCESS) begin
                  field_index_in = field_index_ff + 3'd1;
               end
            end else begin
               case (field_index_ff)
                  FIELD_CALLSIGN: begin
                     if (n < 4'd3) begin
                        if (c != prefix_char(n[1:0])) begin
                           char_code_err = ERR_CALLSIGN;
                        end
                     end else if (in_item.is_alnum) begin
                        for (int b = 0; b < 8; b++) begin
                           if (cs_offset == 4'(b)) begin
                              callsign_in[8*b +: 8] = c;
                           end
                        end
                     end else begin
                        char_code_err = ERR_CALLSIGN;
                     end
                  end
                  FIELD_TAIL: begin
                     if (!in_item.is_tail) begin
                        char_code_err = ERR_TAIL;
                     end else if ((n < 4'd7) && !(in_item.is_dot && !seen_non_dot_ff)) begin
                        // Leading dots are dropped; the rest pack from the low byte.
                        for (int b = 0; b < 7; b++) begin
                           if (tail_count_ff == 3'(b)) begin
                              tail_in[8*b +: 8] = c;
                              tail_count_in     = tail_count_ff + 3'd1;
                              seen_non_dot_in   = 1'b1;
                           end
                        end
                     end
                  end
                  FIELD_IDENT: begin
                     if (!in_item.is_hex) begin
                        char_code_err = ERR_IDENT;
                     end else if (n < 4'd6) begin
                        ident_in = {ident_ff[19:0], in_item.nibble};
                     end
                  end
                  FIELD_TIME: begin
                     if (!in_item.is_digit) begin
                        char_code_err = ERR_TIME;
                     end else if (n < 4'd6) begin
                        time_digits_in = {time_digits_ff[19:0], c[3:0]};
                     end
                  end
                  default: char_code_err = ERR_NONE;
               endcase
               if (first_error_ff == ERR_NONE) begin
                  first_error_in = char_code_err;
               end
               if (n != 4'd15) begin
                  char_in_field_in = n + 4'd1;
               end
            end
         end

         // The final character of a message always restarts the parser.
         if (in_item.last) begin
            field_index_in   = FIELD_CALLSIGN;
            char_in_field_in = '0;
            callsign_in      = '0;
            tail_in          = '0;
            tail_count_in    = '0;
            seen_non_dot_in  = 1'b0;
            ident_in         = '0;
            time_digits_in   = '0;
            first_error_in   = ERR_NONE;
            header_done_in   = 1'b0;
            cs_len_in        = '0;
            ident_empty_in   = 1'b0;
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      rsp_in       = rsp_ff;
      if (take && emit) begin
         out_valid_in = 1'b1;
         rsp_in       = result;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_index_ff   <= FIELD_CALLSIGN;
         char_in_field_ff <= '0;
         callsign_ff      <= '0;
         tail_ff          <= '0;
         tail_count_ff    <= '0;
         seen_non_dot_ff  <= 1'b0;
         ident_ff         <= '0;
         time_digits_ff   <= '0;
         first_error_ff   <= ERR_NONE;
         header_done_ff   <= 1'b0;
         cs_len_ff        <= '0;
         ident_empty_ff   <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         field_index_ff   <= field_index_in;
         char_in_field_ff <= char_in_field_in;
         callsign_ff      <= callsign_in;
         tail_ff          <= tail_in;
         tail_count_ff    <= tail_count_in;
         seen_non_dot_ff  <= seen_non_dot_in;
         ident_ff         <= ident_in;
         time_digits_ff   <= time_digits_in;
         first_error_ff   <= first_error_in;
         header_done_ff   <= header_done_in;
         cs_len_ff        <= cs_len_in;
         ident_empty_ff   <= ident_empty_in;
         out_valid_ff     <= out_valid_in;
      end
      rsp_ff <= rsp_in;
   end

endmodule

// File: rtl/core/message_header_field_parser_core.sv
// The block takes one message character per transfer on req_chan and returns one
// header result on rsp_chan at the first slash, or an error result when a message
// ends without one. It takes one character every clock cycle while results are taken;
// a result is offered once the slash has passed the classifier register, the queue and
// the result register. Depends on mhfp_pkg, mhfp_if, mhfp_front, mhfp_queue and mhfp_back.
module message_header_field_parser_core
   import mhfp_pkg::*;
#(
   parameter int unsigned MAX_CALLSIGN = 8
)
(
   input  logic      clock,
   input  logic      reset,
   mhfp_req_if.sink  req_chan,
   mhfp_rsp_if.source rsp_chan
);

   logic            front_valid;
   logic            front_ready;
   char_item_type   front_item;
   logic            queue_valid;
   logic            queue_ready;
   char_item_type   queue_item;
   rsp_payload_type payload;

   mhfp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .char_code (req_chan.char_code),
      .last      (req_chan.last),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_item  (front_item)
   );

   mhfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_item   (front_item),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_item  (queue_item)
   );

   mhfp_back #(
      .MAX_CALLSIGN (MAX_CALLSIGN)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (queue_valid),
      .in_ready    (queue_ready),
      .in_item     (queue_item),
      .out_valid   (rsp_chan.valid),
      .out_ready   (rsp_chan.ready),
      .out_payload (payload)
   );

   assign rsp_chan.ok           = payload.ok;
   assign rsp_chan.error_code   = payload.error_code;
   assign rsp_chan.callsign     = payload.callsign;
   assign rsp_chan.callsign_len = payload.callsign_len;
   assign rsp_chan.tail         = payload.tail;
   assign rsp_chan.tail_len     = payload.tail_len;
   assign rsp_chan.has_ident    = payload.has_ident;
   assign rsp_chan.ident_value  = payload.ident_value;
   assign rsp_chan.has_time     = payload.has_time;
   assign rsp_chan.hours        = payload.hours;
   assign rsp_chan.minutes      = payload.minutes;
   assign rsp_chan.seconds      = payload.seconds;

   // A good header never carries an error code.
   ok_has_no_error: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ok |-> rsp_chan.error_code == ERR_NONE)
      else $error("ok result carries an error code");

   // A good header has a callsign within the configured length.
   ok_callsign_len: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ok |->
         (rsp_chan.callsign_len != 4'd0) && (rsp_chan.callsign_len <= 4'(MAX_CALLSIGN)))
      else $error("ok result with callsign length out of range");

   // A reported time is always a legal time of day.
   time_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.has_time |->
         rsp_chan.ok && (rsp_chan.hours <= 5'd23) && (rsp_chan.minutes <= 6'd59) &&
         (rsp_chan.seconds <= 6'd59))
      else $error("reported time out of range");

endmodule
